// ===== rtl/analog_ladder_keypad_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the analog ladder keypad decoder
// ----------------------------------------------------------------------------
`ifndef ANALOG_LADDER_KEYPAD_DECODER_DEFINES_SVH
`define ANALOG_LADDER_KEYPAD_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALKD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keypad decoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ALKD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keypad decoder assertion failed");

`endif

// ===== rtl/alkd_pkg.sv =====
// ----------------------------------------------------------------------------
// alkd_pkg
// Types and constants shared by the keypad decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package alkd_pkg;

	localparam int KEY_COUNT = 5;
	localparam int CNT_W     = 4;
	localparam int THR_W     = 11;
	localparam int ADC_W     = 10;

	// Key codes as they appear on the result channel.
	localparam logic [2:0] KEY_NONE  = 3'd0;
	localparam logic [2:0] KEY_UP    = 3'd1;
	localparam logic [2:0] KEY_DOWN  = 3'd2;
	localparam logic [2:0] KEY_LEFT  = 3'd3;
	localparam logic [2:0] KEY_RIGHT = 3'd4;
	localparam logic [2:0] KEY_OK    = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] REG_UP_THR    = 3'd0;
	localparam logic [2:0] REG_DOWN_THR  = 3'd1;
	localparam logic [2:0] REG_LEFT_THR  = 3'd2;
	localparam logic [2:0] REG_RIGHT_THR = 3'd3;
	localparam logic [2:0] REG_OK_THR    = 3'd4;
	localparam logic [2:0] REG_MARGIN    = 3'd5;
	localparam logic [2:0] REG_HOLD      = 3'd6;
	localparam logic [2:0] REG_INTERVAL  = 3'd7;

	localparam logic [THR_W-1:0] THR_RESET      = 11'd2047;
	localparam logic [9:0]       MARGIN_RESET   = 10'd40;
	localparam logic [15:0]      HOLD_RESET     = 16'd600;
	localparam logic [15:0]      INTERVAL_RESET = 16'd150;

	typedef struct packed {
		logic [9:0]  adc_sample;
		logic [31:0] time_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0] key_event;
		logic       is_repeat;
		logic [2:0] held_key;
	} out_item_t;

	typedef struct packed {
		logic [KEY_COUNT-1:0][THR_W-1:0] thr;
		logic [9:0]                      margin;
	} match_cfg_t;

	typedef struct packed {
		logic [15:0] hold_delay;
		logic [15:0] repeat_interval;
	} timing_cfg_t;

	// Classified sample as it waits between front and back.
	typedef struct packed {
		logic [2:0]           best_key;
		logic [KEY_COUNT-1:0] wide_hit;
		logic [31:0]          time_ms;
	} class_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/alkd_front.sv =====
// ----------------------------------------------------------------------------
// alkd_front
// Accepts samples and matches them against the enabled key thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module alkd_front #(
	parameter int NO_PRESS_LEVEL = 1000
) (
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire alkd_pkg::in_item_t    in_data,
	input  wire alkd_pkg::match_cfg_t  mcfg,
	input  wire alkd_pkg::queue_status_t qstat,
	output logic                       push,
	output alkd_pkg::class_item_t      push_data
);

	localparam logic [9:0] NO_PRESS = 10'(NO_PRESS_LEVEL);

	logic [10:0] wide_margin;
	logic [alkd_pkg::KEY_COUNT-1:0] wide_hit;
	logic [2:0]  best_key;

	assign wide_margin = {1'b0, mcfg.margin} + {2'b00, mcfg.margin[9:1]};

	// Nearest enabled threshold within the margin; strict compare keeps the
	// earlier key on a tie. The wide-margin hits are kept for the held key check.
	always_comb begin
		logic [10:0] best_d;
		logic [9:0]  t;
		logic [9:0]  d;
		best_key = alkd_pkg::KEY_NONE;
		best_d   = {1'b0, mcfg.margin} + 11'd1;
		wide_hit = '0;
		for (int k = 0; k < alkd_pkg::KEY_COUNT; k++) begin
			t = mcfg.thr[k][9:0];
			d = (in_data.adc_sample > t) ? (in_data.adc_sample - t) : (t - in_data.adc_sample);
			if (!mcfg.thr[k][10]) begin
				wide_hit[k] = ({1'b0, d} <= wide_margin);
				if (d <= mcfg.margin && {1'b0, d} < best_d) begin
					best_key = 3'(k + 1);
					best_d   = {1'b0, d};
				end
			end
		end
		if (in_data.adc_sample >= NO_PRESS) begin
			best_key = alkd_pkg::KEY_NONE;
			wide_hit = '0;
		end
	end

	assign in_ready           = !qstat.full;
	assign push               = in_valid && in_ready;
	assign push_data.best_key = best_key;
	assign push_data.wide_hit = wide_hit;
	assign push_data.time_ms  = in_data.time_ms;

endmodule

`default_nettype wire

// ===== rtl/alkd_queue.sv =====
// ----------------------------------------------------------------------------
// alkd_queue
// Two-entry queue of classified samples between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module alkd_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire alkd_pkg::class_item_t  push_data,
	input  wire logic                   pop,
	output alkd_pkg::class_item_t       head_data,
	output alkd_pkg::queue_status_t     qstat
);

	alkd_pkg::class_item_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_data   = entry_q[rd_ptr_q];
	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);

endmodule

`default_nettype wire

// ===== rtl/alkd_back.sv =====
// ----------------------------------------------------------------------------
// alkd_back
// Debounce, press and release tracking, auto-repeat and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module alkd_back #(
	parameter int DEBOUNCE_SAMPLES = 3
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire alkd_pkg::queue_status_t qstat,
	input  wire alkd_pkg::class_item_t  head_data,
	input  wire alkd_pkg::timing_cfg_t  tcfg,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output alkd_pkg::out_item_t         out_data
);

	localparam logic [alkd_pkg::CNT_W-1:0] DEB = alkd_pkg::CNT_W'(DEBOUNCE_SAMPLES);

	logic [2:0]                held_q;
	logic [2:0]                last_cand_q;
	logic [alkd_pkg::CNT_W-1:0] press_cnt_q;
	logic [alkd_pkg::CNT_W-1:0] rel_cnt_q;
	logic [31:0]               pressed_time_q;
	logic [31:0]               last_rep_time_q;
	logic                      out_valid_q;
	alkd_pkg::out_item_t       out_data_q;

	logic [7:0]                wide_vec;
	logic [2:0]                cand;
	logic [2:0]                held_n;
	logic [2:0]                last_cand_n;
	logic [alkd_pkg::CNT_W-1:0] press_cnt_n;
	logic [alkd_pkg::CNT_W-1:0] rel_cnt_n;
	logic [31:0]               pressed_time_n;
	logic [31:0]               last_rep_time_n;
	logic [2:0]                event_n;
	logic                      rep_n;
	logic [31:0]               since_press;
	logic [31:0]               since_repeat;

	assign pop = !qstat.empty && (!out_valid_q || out_ready);

	// The held key keeps the sample if it falls inside the wider margin.
	assign wide_vec = {2'b00, head_data.wide_hit, 1'b0};
	assign cand     = (held_q != alkd_pkg::KEY_NONE && wide_vec[held_q]) ? held_q :
	                  head_data.best_key;

	assign since_press  = head_data.time_ms - pressed_time_q;
	assign since_repeat = head_data.time_ms - last_rep_time_q;

	always_comb begin
		held_n          = held_q;
		last_cand_n     = last_cand_q;
		press_cnt_n     = press_cnt_q;
		rel_cnt_n       = rel_cnt_q;
		pressed_time_n  = pressed_time_q;
		last_rep_time_n = last_rep_time_q;
		event_n         = alkd_pkg::KEY_NONE;
		rep_n           = 1'b0;
		if (held_q == alkd_pkg::KEY_NONE) begin
			if (cand == alkd_pkg::KEY_NONE) begin
				last_cand_n = alkd_pkg::KEY_NONE;
				press_cnt_n = '0;
			end else begin
				last_cand_n = cand;
				if (cand != last_cand_q) begin
					press_cnt_n = alkd_pkg::CNT_W'(1);
				end else if (press_cnt_q < DEB) begin
					press_cnt_n = press_cnt_q + alkd_pkg::CNT_W'(1);
				end
				if (press_cnt_n >= DEB) begin
					held_n          = cand;
					pressed_time_n  = head_data.time_ms;
					last_rep_time_n = head_data.time_ms;
					press_cnt_n     = '0;
					rel_cnt_n       = '0;
					event_n         = cand;
				end
			end
		end else if (cand == held_q) begin
			rel_cnt_n = '0;
			if ((held_q == alkd_pkg::KEY_UP || held_q == alkd_pkg::KEY_DOWN) &&
			    since_press >= {16'd0, tcfg.hold_delay} &&
			    since_repeat >= {16'd0, tcfg.repeat_interval}) begin
				last_rep_time_n = head_data.time_ms;
				event_n         = held_q;
				rep_n           = 1'b1;
			end
		end else if (cand == alkd_pkg::KEY_NONE) begin
			if (rel_cnt_q < DEB) begin
				rel_cnt_n = rel_cnt_q + alkd_pkg::CNT_W'(1);
			end
			if (rel_cnt_n >= DEB) begin
				held_n      = alkd_pkg::KEY_NONE;
				last_cand_n = alkd_pkg::KEY_NONE;
				press_cnt_n = '0;
				rel_cnt_n   = '0;
			end
		end else begin
			rel_cnt_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q          <= alkd_pkg::KEY_NONE;
			last_cand_q     <= alkd_pkg::KEY_NONE;
			press_cnt_q     <= '0;
			rel_cnt_q       <= '0;
			pressed_time_q  <= '0;
			last_rep_time_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (pop) begin
				held_q          <= held_n;
				last_cand_q     <= last_cand_n;
				press_cnt_q     <= press_cnt_n;
				rel_cnt_q       <= rel_cnt_n;
				pressed_time_q  <= pressed_time_n;
				last_rep_time_q <= last_rep_time_n;
				out_valid_q     <= 1'b1;
			end else if (out_ready) begin
				out_valid_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q.key_event <= event_n;
			out_data_q.is_repeat <= rep_n;
			out_data_q.held_key  <= held_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/analog_ladder_keypad_decoder.sv =====
// Path: an accepted sample is written into the queue, then popped into the result register
// once that register is free; results queued behind a stalled output wait their turn.
// Throughput: one sample per cycle unless the output stalls, set by the back end state update.
// The two-entry queue lets the input keep accepting while a result waits to be taken.
// Reset: arst_n clears key state, queue and output valid, and loads register defaults.
// ----------------------------------------------------------------------------
// analog_ladder_keypad_decoder
// Resistor-ladder keypad decoder with debounce and up/down auto-repeat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "analog_ladder_keypad_decoder_defines.svh"

module analog_ladder_keypad_decoder #(
	parameter int DEBOUNCE_SAMPLES = 3,
	parameter int NO_PRESS_LEVEL   = 1000
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire alkd_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output alkd_pkg::out_item_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [15:0]         cfg_wdata
);

	alkd_pkg::match_cfg_t    mcfg_q;
	alkd_pkg::timing_cfg_t   tcfg_q;
	alkd_pkg::queue_status_t qstat;
	alkd_pkg::class_item_t   push_data;
	alkd_pkg::class_item_t   head_data;
	logic                    push;
	logic                    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < alkd_pkg::KEY_COUNT; k++) begin
				mcfg_q.thr[k] <= alkd_pkg::THR_RESET;
			end
			mcfg_q.margin          <= alkd_pkg::MARGIN_RESET;
			tcfg_q.hold_delay      <= alkd_pkg::HOLD_RESET;
			tcfg_q.repeat_interval <= alkd_pkg::INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				alkd_pkg::REG_UP_THR:    mcfg_q.thr[0] <= cfg_wdata[10:0];
				alkd_pkg::REG_DOWN_THR:  mcfg_q.thr[1] <= cfg_wdata[10:0];
				alkd_pkg::REG_LEFT_THR:  mcfg_q.thr[2] <= cfg_wdata[10:0];
				alkd_pkg::REG_RIGHT_THR: mcfg_q.thr[3] <= cfg_wdata[10:0];
				alkd_pkg::REG_OK_THR:    mcfg_q.thr[4] <= cfg_wdata[10:0];
				alkd_pkg::REG_MARGIN:    mcfg_q.margin <= cfg_wdata[9:0];
				alkd_pkg::REG_HOLD:      tcfg_q.hold_delay <= cfg_wdata;
				alkd_pkg::REG_INTERVAL:  tcfg_q.repeat_interval <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	alkd_front #(
		.NO_PRESS_LEVEL(NO_PRESS_LEVEL)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.mcfg     (mcfg_q),
		.qstat    (qstat),
		.push     (push),
		.push_data(push_data)
	);

	alkd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head_data(head_data),
		.qstat    (qstat)
	);

	alkd_back #(
		.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.head_data(head_data),
		.tcfg     (tcfg_q),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Only up and down ever repeat.
	`ALKD_ASSERT_IMP(a_repeat_updown, clk, arst_n, out_valid && out_data.is_repeat, out_data.key_event == alkd_pkg::KEY_UP || out_data.key_event == alkd_pkg::KEY_DOWN)

	// Any request reports a key that is held after the update.
	`ALKD_ASSERT_IMP(a_event_held, clk, arst_n, out_valid && out_data.key_event != alkd_pkg::KEY_NONE, out_data.held_key == out_data.key_event)

	// The queue only fills while the result register is blocked.
	`ALKD_ASSERT_IMP(a_full_stalled, clk, arst_n, !in_ready, out_valid)

	// A full queue with a taken result drains an entry, so input opens next cycle.
	`ALKD_ASSERT_NXT(a_full_drains, clk, arst_n, !in_ready && out_ready && !in_valid, in_ready)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the ladder keypad decoder against a cycle-free model of its key
// classification, debounce and up/down auto-repeat. Samples and results
// move over valid/ready channels with random gaps on both sides, and the
// registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import alkd_pkg::*;

	localparam int DEBOUNCE_SAMPLES = 3;
	localparam int NO_KEY_LEVEL     = 1000;
	localparam int DISABLE_LEVEL    = 1024;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_UP_THR;
	logic [15:0] cfg_wdata = '0;

	analog_ladder_keypad_decoder #(
		.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES),
		.NO_PRESS_LEVEL  (NO_KEY_LEVEL)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Register copies and key state of the model.
	logic [10:0] key_level [KEY_COUNT];
	logic [9:0]  match_span;
	logic [15:0] hold_ms;
	logic [15:0] repeat_ms;
	logic [2:0]  cur_held;
	logic [2:0]  cand_prev;
	int          press_run;
	int          release_run;
	logic [31:0] press_start_ms;
	logic [31:0] repeat_mark_ms;

	in_item_t    pending_samples[$];
	out_item_t   expected_results[$];
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          error_count = 0;
	int          results_seen = 0;
	int          hold_off_left = 0;
	bit          hold_off_done = 1'b0;
	logic [31:0] now_ms;
	int          step_max;
	int          queued_count = 0;

	function automatic int level_gap(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [2:0] classify_level(input logic [9:0] lvl);
		logic [2:0] best;
		int best_d, d, wide, k;
		best = KEY_NONE;
		best_d = int'(match_span) + 1;
		if (lvl >= NO_KEY_LEVEL)
			return KEY_NONE;
		// A held key keeps samples within one and a half margins of its level.
		if (cur_held != KEY_NONE) begin
			wide = int'(match_span) + int'(match_span >> 1);
			k = int'(cur_held) - 1;
			if (key_level[k] < DISABLE_LEVEL && level_gap(lvl, key_level[k]) <= wide)
				return cur_held;
		end
		for (k = 0; k < KEY_COUNT; k++) begin
			if (key_level[k] < DISABLE_LEVEL) begin
				d = level_gap(lvl, key_level[k]);
				if (d <= match_span && d < best_d) begin
					best = KEY_UP + k[2:0];
					best_d = d;
				end
			end
		end
		return best;
	endfunction

	function automatic out_item_t decode_sample(input in_item_t item);
		logic [2:0]  cand;
		logic [31:0] since_press, since_repeat;
		out_item_t   res;
		cand = classify_level(item.adc_sample);
		res = '0;
		since_press = item.time_ms - press_start_ms;
		since_repeat = item.time_ms - repeat_mark_ms;
		if (cur_held == KEY_NONE) begin
			if (cand == KEY_NONE) begin
				cand_prev = KEY_NONE;
				press_run = 0;
			end else begin
				if (cand != cand_prev) begin
					cand_prev = cand;
					press_run = 1;
				end else if (press_run < DEBOUNCE_SAMPLES) begin
					press_run++;
				end
				if (press_run >= DEBOUNCE_SAMPLES) begin
					cur_held = cand;
					press_start_ms = item.time_ms;
					repeat_mark_ms = item.time_ms;
					press_run = 0;
					release_run = 0;
					res.key_event = cand;
				end
			end
		end else if (cand == cur_held) begin
			release_run = 0;
			if ((cur_held == KEY_UP || cur_held == KEY_DOWN) &&
			    since_press >= {16'd0, hold_ms} && since_repeat >= {16'd0, repeat_ms}) begin
				repeat_mark_ms = item.time_ms;
				res.key_event = cur_held;
				res.is_repeat = 1'b1;
			end
		end else if (cand == KEY_NONE) begin
			if (release_run < DEBOUNCE_SAMPLES)
				release_run++;
			if (release_run >= DEBOUNCE_SAMPLES) begin
				cur_held = KEY_NONE;
				cand_prev = KEY_NONE;
				press_run = 0;
				release_run = 0;
			end
		end else begin
			release_run = 0;
		end
		res.held_key = cur_held;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input out_item_t want,
	                               input out_item_t got);
		error_count++;
		if (error_count <= 10)
			$display("%0t %s: expected event %0d repeat %0d held %0d, got event %0d repeat %0d held %0d",
			         $realtime, what, want.key_event, want.is_repeat, want.held_key,
			         got.key_event, got.is_repeat, got.held_key);
	endtask

	// Sample requests: the next one is taken from the queue once the current one is gone.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_results.push_back(decode_sample(in_data));
			if (!in_valid || in_ready) begin
				if (pending_samples.size() > 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
					in_data <= pending_samples.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result side: checks each accepted result and holds off once for a long stretch.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", '0, out_data);
				end else begin
					want = expected_results.pop_front();
					if (out_data.key_event !== want.key_event ||
					    out_data.is_repeat !== want.is_repeat ||
					    out_data.held_key !== want.held_key)
						report_mismatch("result mismatch", want, out_data);
				end
				results_seen++;
				if (!hold_off_done && results_seen == 150) begin
					hold_off_done = 1'b1;
					hold_off_left = 300;
				end
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_UP_THR, REG_DOWN_THR, REG_LEFT_THR, REG_RIGHT_THR, REG_OK_THR: begin
				key_level[idx] = val[10:0];
			end
			REG_MARGIN: begin
				match_span = val[9:0];
			end
			REG_HOLD: begin
				hold_ms = val;
			end
			default: begin
				repeat_ms = val;
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		write_reg(REG_UP_THR, 16'($urandom_range(1100, 0)));
		write_reg(REG_DOWN_THR, 16'($urandom_range(1100, 0)));
		write_reg(REG_LEFT_THR, 16'($urandom_range(1100, 0)));
		write_reg(REG_RIGHT_THR, 16'($urandom_range(1100, 0)));
		write_reg(REG_OK_THR, 16'($urandom_range(1100, 0)));
		write_reg(REG_MARGIN, 16'($urandom_range(60, 5)));
		write_reg(REG_HOLD, 16'($urandom_range(200, 20)));
		write_reg(REG_INTERVAL, 16'($urandom_range(60, 0)));
	endtask

	// Waits until every request has gone in and every result has come out.
	task automatic drain();
		while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic push_at(input int lvl, input logic [31:0] t);
		pending_samples.push_back(in_item_t'{adc_sample: lvl[9:0], time_ms: t});
	endtask

	task automatic add_sample(input int lvl);
		if ($urandom_range(99, 0) < 2)
			now_ms = $urandom();
		else
			now_ms += $urandom_range(step_max, 0);
		push_at(lvl, now_ms);
		queued_count++;
	endtask

	// A level around the key's threshold, or anywhere when the key is disabled.
	function automatic int near_level(input int lvl, input int span);
		int s;
		if (lvl >= DISABLE_LEVEL)
			return $urandom_range(1023, 0);
		s = $urandom_range(1, 0) ? lvl + $urandom_range(span, 0) : lvl - $urandom_range(span, 0);
		return (s < 0) ? 0 : (s > 1023) ? 1023 : s;
	endfunction

	// Mostly press, hold and release sequences, with noise and cut-short presses.
	task automatic random_items(input int count);
		int target, k, n, i, span;
		target = queued_count + count;
		while (queued_count < target) begin
			if ($urandom_range(99, 0) < 75) begin
				k = $urandom_range(KEY_COUNT - 1, 0);
				span = int'(match_span);
				n = $urandom_range(6, 2);
				for (i = 0; i < n; i++)
					add_sample(near_level(key_level[k], span));
				n = $urandom_range(12, 0);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(7, 0) == 0)
						add_sample($urandom_range(1023, 0));
					else
						add_sample(near_level(key_level[k], span + span / 2));
				end
				n = $urandom_range(4, 2);
				for (i = 0; i < n; i++)
					add_sample($urandom_range(1023, NO_KEY_LEVEL));
			end else begin
				n = $urandom_range(3, 1);
				for (i = 0; i < n; i++)
					add_sample($urandom_range(1023, 0));
			end
		end
	endtask

	initial begin
		logic [31:0] t0;
		for (int k = 0; k < KEY_COUNT; k++)
			key_level[k] = THR_RESET;
		match_span = MARGIN_RESET;
		hold_ms = HOLD_RESET;
		repeat_ms = INTERVAL_RESET;
		cur_held = KEY_NONE;
		cand_prev = KEY_NONE;
		press_run = 0;
		release_run = 0;
		press_start_ms = '0;
		repeat_mark_ms = '0;
		t0 = 32'hFFFF_FFD0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 8;
		rx_idle_pct = 54;
		// Every key is disabled after reset.
		push_at(0, 32'd0);
		push_at(999, 32'd1);
		push_at(1023, 32'd2);
		drain();

		write_reg(REG_UP_THR, 16'd100);
		write_reg(REG_DOWN_THR, 16'd180);
		write_reg(REG_LEFT_THR, 16'd500);
		write_reg(REG_RIGHT_THR, 16'd700);
		write_reg(REG_OK_THR, 16'd900);
		write_reg(REG_MARGIN, 16'd40);
		write_reg(REG_HOLD, 16'd50);
		write_reg(REG_INTERVAL, 16'd20);
		// Up press ending on a tie with down, so up wins by order.
		push_at(100, t0);
		push_at(100, t0 + 5);
		push_at(140, t0 + 10);
		// Inside the wider margin of the held key, then another key, then one empty sample.
		push_at(159, t0 + 20);
		push_at(500, t0 + 30);
		push_at(1023, t0 + 40);
		// Repeats across the wrap of the millisecond count.
		push_at(100, t0 + 70);
		push_at(100, t0 + 80);
		push_at(100, t0 + 90);
		push_at(1000, t0 + 100);
		push_at(1023, t0 + 110);
		push_at(1010, t0 + 120);
		// Ok never repeats.
		push_at(900, t0 + 130);
		push_at(900, t0 + 140);
		push_at(900, t0 + 150);
		push_at(900, t0 + 2000);
		push_at(1023, t0 + 2010);
		push_at(1023, t0 + 2020);
		push_at(1023, t0 + 2030);
		push_at(0, t0 + 2040);
		push_at(180, t0 + 2050);
		push_at(180, t0 + 2060);
		push_at(180, t0 + 2070);
		drain();
		// Disable the held key: its level now matches nothing and the key is released.
		write_reg(REG_DOWN_THR, 16'd1024);
		push_at(180, t0 + 2080);
		push_at(180, t0 + 2090);
		push_at(180, t0 + 2100);
		push_at(180, t0 + 2110);
		drain();

		now_ms = t0 + 3000;
		step_max = 20;
		random_config();
		random_items(300);
		drain();

		tx_idle_pct = 54;
		rx_idle_pct = 8;
		step_max = 3;
		write_reg(REG_UP_THR, 16'd0);
		write_reg(REG_DOWN_THR, 16'd999);
		write_reg(REG_LEFT_THR, 16'd1024);
		write_reg(REG_RIGHT_THR, 16'd512);
		write_reg(REG_OK_THR, 16'hFFFF);
		write_reg(REG_MARGIN, 16'd0);
		write_reg(REG_HOLD, 16'd0);
		write_reg(REG_INTERVAL, 16'd0);
		random_items(150);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		step_max = 5000;
		write_reg(REG_UP_THR, 16'($urandom_range(200, 0)));
		write_reg(REG_DOWN_THR, 16'($urandom_range(400, 200)));
		write_reg(REG_LEFT_THR, 16'($urandom_range(600, 400)));
		write_reg(REG_RIGHT_THR, 16'($urandom_range(800, 600)));
		write_reg(REG_OK_THR, 16'($urandom_range(1023, 800)));
		write_reg(REG_MARGIN, 16'hFFFF);
		write_reg(REG_HOLD, 16'hFFFF);
		write_reg(REG_INTERVAL, 16'hFFFF);
		random_items(150);
		drain();

		step_max = 30;
		random_config();
		random_items(150);
		drain();

		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
